FILE: src/fsup_pkg.sv
`timescale 1ns / 1ps
// fsup_pkg: shared types, codes and the action mapping function for the
// failsafe event supervisor; no dependencies
package fsup_pkg;

  localparam int EVT_W     = 8;
  localparam int TIME_W    = 32;
  localparam int TMO_W     = 20;
  localparam int ACT_W     = 3;
  localparam int REQ_W     = 3;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 20;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 16;

  localparam logic [EVT_W-1:0] EVT_THROTTLE = 8'h01;
  localparam logic [EVT_W-1:0] EVT_GCS      = 8'h02;

  localparam logic [TMO_W-1:0] TIMEOUT_RST = 20'd1500;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE          = 3'd0,
    ACT_RTL           = 3'd1,
    ACT_HOLD          = 3'd2,
    ACT_SMARTRTL      = 3'd3,
    ACT_SMARTRTL_HOLD = 3'd4,
    ACT_TERMINATE     = 3'd5,
    ACT_LOITER_HOLD   = 3'd6
  } action_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_NONE     = 3'd0,
    REQ_SMARTRTL = 3'd1,
    REQ_RTL      = 3'd2,
    REQ_HOLD     = 3'd3,
    REQ_LOITER   = 3'd4
  } mode_req_t;

  typedef enum logic [MODE_W-1:0] {
    VEH_OTHER = 2'd0,
    VEH_AUTO  = 2'd1,
    VEH_RTL   = 2'd2,
    VEH_HOLD  = 2'd3
  } veh_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FAILSAFE_ACTION = 3'd0,
    REG_TIMEOUT_MS      = 3'd1,
    REG_THR_CONTINUE    = 3'd2,
    REG_GCS_CONTINUE    = 3'd3,
    REG_ACTIVE_IN_HOLD  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [EVT_W-1:0]  event_mask;
    logic              event_on;
    logic [TIME_W-1:0] now_ms;
    logic [MODE_W-1:0] current_mode;
    logic [ACT_W-1:0]  battery_action;
    logic              smartrtl_ok;
    logic              rtl_ok;
    logic              loiter_ok;
  } evt_item_t;

  typedef struct packed {
    logic [REQ_W-1:0] mode_request;
    logic             disarm;
  } act_out_t;

  typedef struct packed {
    logic [REQ_W-1:0] mode_request;
    logic             disarm;
    logic             fired;
    logic             cleared;
    logic             continue_auto;
    logic [EVT_W-1:0] active_mask;
  } result_t;

  function automatic act_out_t map_action(input logic [ACT_W-1:0] act,
                                          input logic s_ok,
                                          input logic r_ok,
                                          input logic l_ok);
    act_out_t o;
    o.mode_request = REQ_NONE;
    o.disarm       = 1'b0;
    case (act)
      ACT_RTL:           o.mode_request = r_ok ? REQ_RTL : REQ_HOLD;
      ACT_HOLD:          o.mode_request = REQ_HOLD;
      ACT_SMARTRTL:      o.mode_request = s_ok ? REQ_SMARTRTL
                                               : (r_ok ? REQ_RTL : REQ_HOLD);
      ACT_SMARTRTL_HOLD: o.mode_request = s_ok ? REQ_SMARTRTL : REQ_HOLD;
      ACT_TERMINATE:     o.disarm = 1'b1;
      ACT_LOITER_HOLD:   o.mode_request = l_ok ? REQ_LOITER : REQ_HOLD;
      default:           o.mode_request = REQ_NONE;
    endcase
    return o;
  endfunction

endpackage

FILE: src/failsafe_event_supervisor.sv
`timescale 1ns / 1ps
// failsafe_event_supervisor: an input transaction passes the input register, then
// the result register, before the result is valid; throughput one transaction
// per cycle while out_tready does not stall the result register.
// rst_n (synchronous, active low) clears event state, start time, pipeline
// valids and loads the register defaults. depends on fsup_pkg
module failsafe_event_supervisor
  import fsup_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // event_mask, event_on, now_ms, current_mode, battery_action,
  // smartrtl_ok, rtl_ok, loiter_ok, zero pad
  input  logic [IN_TDATA_W-1:0]   in_tdata,
  // kind
  input  logic                    in_tuser,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // mode_request, disarm, fired, cleared, continue_auto, active_mask, zero pad
  output logic [OUT_TDATA_W-1:0]  out_tdata,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DAT_W-1:0]    cfg_data
);

  logic              s1_valid_r;
  logic              s1_kind_r;
  evt_item_t         s1_item_r;
  logic              out_valid_r;
  result_t           out_res_r;
  logic [EVT_W-1:0]  active_r, active_nxt;
  logic [EVT_W-1:0]  trig_r, trig_nxt;
  logic [TIME_W-1:0] start_r, start_nxt;
  logic [ACT_W-1:0]  cfg_action_r;
  logic [TMO_W-1:0]  cfg_timeout_r;
  logic              cfg_thr_cont_r;
  logic              cfg_gcs_cont_r;
  logic              cfg_in_hold_r;

  logic              s1_adv;
  logic              in_acc;
  evt_item_t         in_item;
  result_t           res_nxt;
  act_out_t          batt_act;
  act_out_t          fs_act;
  logic [EVT_W-1:0]  upd_mask;
  logic [EVT_W-1:0]  trig_kept;
  logic [TIME_W-1:0] start_eff;
  logic [TIME_W-1:0] elapsed;
  logic              fire;
  logic              cont;

  assign in_item = '{
    event_mask:     in_tdata[7:0],
    event_on:       in_tdata[8],
    now_ms:         in_tdata[40:9],
    current_mode:   in_tdata[42:41],
    battery_action: in_tdata[45:43],
    smartrtl_ok:    in_tdata[46],
    rtl_ok:         in_tdata[47],
    loiter_ok:      in_tdata[48]
  };

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_item;
      s1_kind_r <= in_tuser;
    end
  end

  always_comb begin
    upd_mask  = s1_item_r.event_on ? (active_r | s1_item_r.event_mask)
                                   : (active_r & ~s1_item_r.event_mask);
    start_eff = (active_r == '0 && upd_mask != '0) ? s1_item_r.now_ms : start_r;
    trig_kept = trig_r & upd_mask;
    elapsed   = s1_item_r.now_ms - start_eff;
    fire      = trig_kept == '0 && upd_mask != '0 &&
                elapsed > {{(TIME_W-TMO_W){1'b0}}, cfg_timeout_r} &&
                s1_item_r.current_mode != VEH_RTL &&
                (s1_item_r.current_mode != VEH_HOLD || cfg_in_hold_r);
    cont      = s1_item_r.current_mode == VEH_AUTO &&
                ((s1_item_r.event_mask == EVT_THROTTLE && cfg_thr_cont_r) ||
                 (s1_item_r.event_mask == EVT_GCS && cfg_gcs_cont_r));
    batt_act  = map_action(s1_item_r.battery_action, s1_item_r.smartrtl_ok,
                           s1_item_r.rtl_ok, s1_item_r.loiter_ok);
    fs_act    = map_action(cfg_action_r, s1_item_r.smartrtl_ok,
                           s1_item_r.rtl_ok, s1_item_r.loiter_ok);

    active_nxt = active_r;
    trig_nxt   = trig_r;
    start_nxt  = start_r;
    res_nxt    = '0;
    if (s1_kind_r) begin
      res_nxt.mode_request = batt_act.mode_request;
      res_nxt.disarm       = batt_act.disarm;
      res_nxt.active_mask  = active_r;
    end else begin
      active_nxt          = upd_mask;
      start_nxt           = start_eff;
      trig_nxt            = fire ? upd_mask : trig_kept;
      res_nxt.cleared     = trig_r != '0 && upd_mask == '0;
      res_nxt.active_mask = upd_mask;
      if (fire) begin
        res_nxt.fired         = 1'b1;
        res_nxt.continue_auto = cont;
        if (!cont) begin
          res_nxt.mode_request = fs_act.mode_request;
          res_nxt.disarm       = fs_act.disarm;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      trig_r   <= '0;
      start_r  <= '0;
    end else if (s1_adv) begin
      active_r <= active_nxt;
      trig_r   <= trig_nxt;
      start_r  <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_action_r   <= ACT_HOLD;
      cfg_timeout_r  <= TIMEOUT_RST;
      cfg_thr_cont_r <= 1'b0;
      cfg_gcs_cont_r <= 1'b0;
      cfg_in_hold_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FAILSAFE_ACTION: cfg_action_r   <= cfg_data[ACT_W-1:0];
        REG_TIMEOUT_MS:      cfg_timeout_r  <= cfg_data[TMO_W-1:0];
        REG_THR_CONTINUE:    cfg_thr_cont_r <= cfg_data[0];
        REG_GCS_CONTINUE:    cfg_gcs_cont_r <= cfg_data[0];
        REG_ACTIVE_IN_HOLD:  cfg_in_hold_r  <= cfg_data[0];
        default:             cfg_in_hold_r  <= cfg_in_hold_r;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.active_mask, out_res_r.continue_auto,
                       out_res_r.cleared, out_res_r.fired, out_res_r.disarm,
                       out_res_r.mode_request};

`ifndef SYNTHESIS
  // a firing transaction always leaves some event bit active
  a_fire_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.fired |-> out_res_r.active_mask != '0)
    else $error("fired with empty active mask");

  a_fire_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.fired && out_res_r.cleared))
    else $error("fired and cleared together");

  a_cont_fired: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.continue_auto |->
      out_res_r.fired && !out_res_r.disarm && out_res_r.mode_request == REQ_NONE)
    else $error("continue without fire or with action");

  // triggered bits never exceed the active set
  a_trig_subset: assert property (@(posedge clk) disable iff (!rst_n)
    (trig_r & ~active_r) == '0)
    else $error("triggered bit not active");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !s1_valid_r)
    else $error("pipeline valid after reset");
`endif

endmodule
